// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk_i, idle during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/pcx_rle_pkg.sv =====
// ----------------------------------------------------------------------------
// pcx_rle_pkg
// shared widths, register indexes and controller/datapath signal groups
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pcx_rle_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned WIDTH_W    = 12;
  localparam int unsigned HEIGHT_W   = 16;
  localparam int unsigned LBYTES_W   = 12;
  localparam int unsigned PCOUNT_W   = 3;
  localparam int unsigned PLANE_W    = 2;
  localparam int unsigned RUN_W      = 6;
  localparam int unsigned COL_OUT_W  = 11;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_BYTES   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_COUNT  = 2'd3;

  localparam logic [BYTE_W-1:0] RUN_MARK = 8'hC0;
  localparam logic [BYTE_W-1:0] RUN_MASK = 8'h3F;

  typedef struct packed {
    logic sync_load;
    logic sync_step;
    logic load_byte;
    logic store_wr;
    logic px_start;
    logic rd_issue;
    logic rd_capture;
    logic emit;
    logic emit_last;
    logic advance;
  } ctl_cmd_t;

  typedef struct packed {
    logic cfg_wr;
    logic sync_busy;
    logic is_store;
    logic is_pixel;
    logic line_last;
    logic px_last;
    logic single_plane;
    logic rd_last;
    logic out_busy;
  } dp_status_t;

endpackage

// ===== rtl/core/pcx_rle_ctrl.sv =====
// ----------------------------------------------------------------------------
// pcx_rle_ctrl
// run header tracking, repeat counting and per-byte sequencing
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module pcx_rle_ctrl (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  input  logic [pcx_rle_pkg::BYTE_W-1:0]       code_byte_i,
  output logic                                 in_stall_o,
  input  pcx_rle_pkg::dp_status_t              sts_i,
  output pcx_rle_pkg::ctl_cmd_t                cmd_o
);

  import pcx_rle_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SYNC = 3'd1;
  localparam logic [2:0] ST_PUT  = 3'd2;
  localparam logic [2:0] ST_RD   = 3'd3;
  localparam logic [2:0] ST_CAP  = 3'd4;
  localparam logic [2:0] ST_EMIT = 3'd5;

  logic [2:0]       state_q, state_d;
  logic             dirty_q, dirty_d;
  logic             hdr_q, hdr_d;
  logic [RUN_W-1:0] pend_q, pend_d;
  logic [RUN_W-1:0] rem_q, rem_d;
  logic             run_done;

  assign run_done = (rem_q == RUN_W'(1)) || sts_i.line_last;

  always_comb begin
    cmd_o      = '0;
    state_d    = state_q;
    dirty_d    = dirty_q | sts_i.cfg_wr;
    hdr_d      = hdr_q;
    pend_d     = pend_q;
    rem_d      = rem_q;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        if (dirty_q) begin
          cmd_o.sync_load = 1'b1;
          dirty_d         = sts_i.cfg_wr;
          state_d         = ST_SYNC;
        end else if (!sts_i.cfg_wr) begin
          in_stall_o = 1'b0;
          if (in_valid_i) begin
            if (hdr_q) begin
              hdr_d  = 1'b0;
              pend_d = '0;
              if (pend_q != '0) begin
                cmd_o.load_byte = 1'b1;
                rem_d           = pend_q;
                state_d         = ST_PUT;
              end
            end else if ((code_byte_i & RUN_MARK) == RUN_MARK) begin
              hdr_d  = 1'b1;
              pend_d = RUN_W'(code_byte_i & RUN_MASK);
            end else begin
              cmd_o.load_byte = 1'b1;
              rem_d           = RUN_W'(1);
              state_d         = ST_PUT;
            end
          end
        end
      end
      ST_SYNC: begin
        cmd_o.sync_step = 1'b1;
        if (!sts_i.sync_busy) begin
          state_d = ST_IDLE;
        end
      end
      ST_PUT: begin
        if (sts_i.is_pixel) begin
          cmd_o.px_start = 1'b1;
          state_d        = sts_i.single_plane ? ST_EMIT : ST_RD;
        end else begin
          cmd_o.store_wr = sts_i.is_store;
          cmd_o.advance  = 1'b1;
          if (run_done) begin
            state_d = ST_IDLE;
          end else begin
            rem_d = rem_q - RUN_W'(1);
          end
        end
      end
      ST_RD: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = ST_CAP;
      end
      ST_CAP: begin
        cmd_o.rd_capture = 1'b1;
        state_d          = sts_i.rd_last ? ST_EMIT : ST_RD;
      end
      ST_EMIT: begin
        if (!sts_i.out_busy) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_last = (rem_q == RUN_W'(1)) || sts_i.px_last;
          cmd_o.advance   = 1'b1;
          if (run_done) begin
            state_d = ST_IDLE;
          end else begin
            rem_d   = rem_q - RUN_W'(1);
            state_d = ST_PUT;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      dirty_q <= 1'b0;
      hdr_q   <= 1'b0;
      pend_q  <= '0;
      rem_q   <= '0;
    end else begin
      state_q <= state_d;
      dirty_q <= dirty_d;
      hdr_q   <= hdr_d;
      pend_q  <= pend_d;
      rem_q   <= rem_d;
    end
  end

  `ASSERT_IMPL(a_rem_live,
    (state_q == ST_PUT || state_q == ST_RD || state_q == ST_CAP || state_q == ST_EMIT),
    rem_q != '0, "repeat count empty while a byte is in work")
  `ASSERT_IMPL(a_hdr_idle, hdr_q, state_q == ST_IDLE, "run header pending outside idle")
  `ASSERT_IMPL(a_last_at_eol, cmd_o.emit && sts_i.line_last, cmd_o.emit_last,
    "pixel closing a scanline not marked last of run")
  `ASSERT_IMPL(a_cfg_synced, cmd_o.load_byte, !dirty_q, "byte taken before position resync")
  `ASSERT_NEXT(a_load_put, cmd_o.load_byte, state_q == ST_PUT, "loaded byte not decoded")

endmodule

// ===== rtl/core/pcx_rle_datapath.sv =====
// ----------------------------------------------------------------------------
// pcx_rle_datapath
// config registers, line position, plane line store and pixel output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcx_rle_datapath #(
  parameter int unsigned MAX_LINE_BYTES = 2048,
  parameter int unsigned MAX_PLANES     = 4
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  input  logic [pcx_rle_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [pcx_rle_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic [pcx_rle_pkg::BYTE_W-1:0]        code_byte_i,
  input  logic                                  out_stall_i,
  output logic                                  out_valid_o,
  output logic [pcx_rle_pkg::BYTE_W-1:0]        pixel_byte_a_o,
  output logic [pcx_rle_pkg::BYTE_W-1:0]        pixel_byte_b_o,
  output logic [pcx_rle_pkg::BYTE_W-1:0]        pixel_byte_c_o,
  output logic [pcx_rle_pkg::BYTE_W-1:0]        pixel_byte_d_o,
  output logic [pcx_rle_pkg::COL_OUT_W-1:0]     pixel_column_o,
  output logic                                  line_end_o,
  output logic                                  image_end_o,
  output logic                                  last_of_run_o,
  input  pcx_rle_pkg::ctl_cmd_t                 cmd_i,
  output pcx_rle_pkg::dp_status_t               sts_o
);

  import pcx_rle_pkg::*;

  localparam int unsigned STORE_DEPTH =
    (MAX_PLANES > 1) ? (MAX_PLANES - 1) * MAX_LINE_BYTES : 2;
  localparam int unsigned AW  = $clog2(STORE_DEPTH);
  localparam int unsigned PW  = $clog2(MAX_LINE_BYTES * MAX_PLANES);
  localparam int unsigned LBW = $clog2(MAX_LINE_BYTES + 1);

  // programmed registers
  logic [WIDTH_W-1:0]  width_q;
  logic [HEIGHT_W-1:0] height_q;
  logic [LBYTES_W-1:0] lbytes_q;
  logic [PCOUNT_W-1:0] pcount_q;

  // clamped working values
  logic [LBW-1:0]      lb_q, lb_d;
  logic [LBW-1:0]      wd_q, wd_d;
  logic [PCOUNT_W-1:0] pc_q, pc_d;
  logic [HEIGHT_W-1:0] ht_q, ht_d;
  logic [31:0]         lb_sel, wd_sel, pc_sel;

  // position
  logic [PW-1:0]       pos_q, col_q, base_pos;
  logic [PLANE_W-1:0]  plane_q, k_q;
  logic                wrap_q;
  logic [HEIGHT_W-1:0] row_q;
  logic [HEIGHT_W:0]   row_inc;

  logic [BYTE_W-1:0]   val_q;
  logic [BYTE_W-1:0]   slot_b_q, slot_c_q, slot_d_q;

  logic [BYTE_W-1:0]   mem [STORE_DEPTH];
  logic [BYTE_W-1:0]   rdata_q;
  logic [AW-1:0]       wr_addr, rd_addr;
  logic [31:0]         col32, lb32, wd32, rd_plane;

  logic                out_valid_q;

  always_comb begin
    lb_sel = 32'(lbytes_q);
    if (lb_sel == 32'd0) lb_sel = 32'd1;
    if (lb_sel > MAX_LINE_BYTES) lb_sel = MAX_LINE_BYTES;
    wd_sel = 32'(width_q);
    if (wd_sel == 32'd0) wd_sel = 32'd1;
    if (wd_sel > lb_sel) wd_sel = lb_sel;
    pc_sel = 32'(pcount_q);
    if (pc_sel == 32'd0) pc_sel = 32'd1;
    if (pc_sel > MAX_PLANES) pc_sel = MAX_PLANES;
    lb_d = LBW'(lb_sel);
    wd_d = LBW'(wd_sel);
    pc_d = PCOUNT_W'(pc_sel);
    ht_d = (height_q == '0) ? HEIGHT_W'(1) : height_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_W'(1);
      height_q <= HEIGHT_W'(1);
      lbytes_q <= LBYTES_W'(1);
      pcount_q <= PCOUNT_W'(1);
      lb_q     <= LBW'(1);
      wd_q     <= LBW'(1);
      pc_q     <= PCOUNT_W'(1);
      ht_q     <= HEIGHT_W'(1);
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_IMAGE_WIDTH:  width_q  <= cfg_data_i[WIDTH_W-1:0];
          REG_IMAGE_HEIGHT: height_q <= cfg_data_i[HEIGHT_W-1:0];
          REG_LINE_BYTES:   lbytes_q <= cfg_data_i[LBYTES_W-1:0];
          REG_PLANE_COUNT:  pcount_q <= cfg_data_i[PCOUNT_W-1:0];
        endcase
      end
      lb_q <= lb_d;
      wd_q <= wd_d;
      pc_q <= pc_d;
      ht_q <= ht_d;
    end
  end

  assign col32    = 32'(col_q);
  assign lb32     = 32'(lb_q);
  assign wd32     = 32'(wd_q);
  assign base_pos = wrap_q ? '0 : pos_q;
  assign row_inc  = (HEIGHT_W + 1)'(row_q) + (HEIGHT_W + 1)'(1);

  always_comb begin
    sts_o              = '0;
    sts_o.cfg_wr       = cfg_valid_i;
    sts_o.sync_busy    = col32 >= lb32;
    sts_o.is_store     = (32'(plane_q) + 32'd1) < 32'(pc_q);
    sts_o.is_pixel     = !sts_o.is_store && (col32 < wd32);
    sts_o.line_last    = !sts_o.is_store && (col32 + 32'd1 == lb32);
    sts_o.px_last      = col32 + 32'd1 == wd32;
    sts_o.single_plane = pc_q == PCOUNT_W'(1);
    sts_o.rd_last      = (32'(k_q) + 32'd1) == 32'(pc_q);
    sts_o.out_busy     = out_valid_q && out_stall_i;
  end

  // position tracking, resync after register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      col_q   <= '0;
      plane_q <= '0;
      wrap_q  <= 1'b0;
      row_q   <= '0;
    end else if (cmd_i.sync_load) begin
      col_q   <= pos_q;
      plane_q <= '0;
      wrap_q  <= 1'b0;
    end else if (cmd_i.sync_step) begin
      if (sts_o.sync_busy) begin
        if (sts_o.is_store) begin
          col_q   <= col_q - PW'(lb_q);
          plane_q <= plane_q + PLANE_W'(1);
        end else begin
          col_q   <= '0;
          plane_q <= '0;
          wrap_q  <= 1'b1;
        end
      end
    end else if (cmd_i.advance) begin
      wrap_q <= 1'b0;
      if (sts_o.line_last) begin
        pos_q   <= '0;
        col_q   <= '0;
        plane_q <= '0;
        row_q   <= (row_inc >= (HEIGHT_W + 1)'(ht_q)) ? '0 : row_inc[HEIGHT_W-1:0];
      end else begin
        pos_q <= base_pos + PW'(1);
        if (col32 + 32'd1 == lb32) begin
          col_q   <= '0;
          plane_q <= plane_q + PLANE_W'(1);
        end else begin
          col_q <= col_q + PW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= '0;
    end else if (cmd_i.px_start) begin
      k_q <= PLANE_W'(1);
    end else if (cmd_i.rd_capture) begin
      k_q <= k_q + PLANE_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_byte) begin
      val_q <= code_byte_i;
    end
    if (cmd_i.px_start) begin
      slot_b_q <= '0;
      slot_c_q <= '0;
      slot_d_q <= '0;
    end else if (cmd_i.rd_capture) begin
      case (k_q)
        PLANE_W'(1): slot_b_q <= rdata_q;
        PLANE_W'(2): slot_c_q <= rdata_q;
        PLANE_W'(3): slot_d_q <= rdata_q;
        default: ;
      endcase
    end
  end

  // plane line store, one write or one read a cycle
  assign rd_plane = 32'(pc_q) - 32'(k_q) - 32'd1;
  assign wr_addr  = AW'(32'(plane_q) * MAX_LINE_BYTES + col32);
  assign rd_addr  = AW'(rd_plane * MAX_LINE_BYTES + col32);

  always_ff @(posedge clk_i) begin
    if (cmd_i.store_wr) begin
      mem[wr_addr] <= val_q;
    end
    if (cmd_i.rd_issue) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      pixel_byte_a_o <= val_q;
      pixel_byte_b_o <= slot_b_q;
      pixel_byte_c_o <= slot_c_q;
      pixel_byte_d_o <= slot_d_q;
      pixel_column_o <= col32[COL_OUT_W-1:0];
      line_end_o     <= sts_o.px_last;
      image_end_o    <= sts_o.px_last && (row_inc == (HEIGHT_W + 1)'(ht_q));
      last_of_run_o  <= cmd_i.emit_last;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/core/pcx_rle_scanline_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// pcx_rle_scanline_decoder_unit
// run-length byte decoder producing interleaved pixels from planar scanlines
// ----------------------------------------------------------------------------
//  channel   signals                                   direction
//  input     in_valid_i, in_stall_o, code_byte_i       in
//  output    out_valid_o, out_stall_i, pixel_*_o, ...  out
//  config    cfg_valid_i, cfg_ready_o, index, data     in
//
//  a byte is taken in idle; header and zero-length run bytes leave the decoder in idle
//  each repeat of a stored or padding byte is handled in put; a pixel also reads the other planes
//  pixel cost is set by the line store, where each plane read is issued and then captured
//  after a register write the position is resynced before the next byte is taken
//  a stalled output holds only the pixel that is waiting to be emitted
//  reset clears position and run state and sets the registers to 1; the line store is not cleared
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcx_rle_scanline_decoder_unit #(
  parameter int unsigned MAX_LINE_BYTES = 2048,
  parameter int unsigned MAX_PLANES     = 4
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [pcx_rle_pkg::BYTE_W-1:0]     code_byte_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [pcx_rle_pkg::BYTE_W-1:0]     pixel_byte_a_o,
  output logic [pcx_rle_pkg::BYTE_W-1:0]     pixel_byte_b_o,
  output logic [pcx_rle_pkg::BYTE_W-1:0]     pixel_byte_c_o,
  output logic [pcx_rle_pkg::BYTE_W-1:0]     pixel_byte_d_o,
  output logic [pcx_rle_pkg::COL_OUT_W-1:0]  pixel_column_o,
  output logic                               line_end_o,
  output logic                               image_end_o,
  output logic                               last_of_run_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [pcx_rle_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pcx_rle_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  import pcx_rle_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t sts;

  assign cfg_ready_o = 1'b1;

  pcx_rle_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .code_byte_i (code_byte_i),
    .in_stall_o  (in_stall_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pcx_rle_datapath #(
    .MAX_LINE_BYTES (MAX_LINE_BYTES),
    .MAX_PLANES     (MAX_PLANES)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .code_byte_i    (code_byte_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .pixel_byte_a_o (pixel_byte_a_o),
    .pixel_byte_b_o (pixel_byte_b_o),
    .pixel_byte_c_o (pixel_byte_c_o),
    .pixel_byte_d_o (pixel_byte_d_o),
    .pixel_column_o (pixel_column_o),
    .line_end_o     (line_end_o),
    .image_end_o    (image_end_o),
    .last_of_run_o  (last_of_run_o),
    .cmd_i          (cmd),
    .sts_o          (sts)
  );

endmodule
